[rtl/rtufl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtufl_pkg: shared types and constants of the RTU frame link controller
// Frame store geometry, command and link state codes, register indexes and
// the structs that travel between the control, store and result queue.
// ----------------------------------------------------------------------------
package rtufl_pkg;

	localparam int FRAME_BYTES = 256;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
	localparam int MAGIC_BYTES = 8;

	typedef enum logic [2:0] {
		CMD_RX_BYTE       = 3'd0,
		CMD_LINE_IDLE     = 3'd1,
		CMD_QUIET_TIMEOUT = 3'd2,
		CMD_REPLY_READY   = 3'd3,
		CMD_TX_COMPLETE   = 3'd4,
		CMD_READ          = 3'd5,
		CMD_WRITE         = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		LS_RX   = 2'd0,
		LS_DONE = 2'd1,
		LS_WAIT = 2'd2,
		LS_TX   = 2'd3
	} link_state_t;

	typedef enum logic [1:0] {
		CFG_MAGIC_VALUE    = 2'd0,
		CFG_MAGIC_LENGTH   = 2'd1,
		CFG_MAGIC_CHECK_EN = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef struct packed {
		link_state_t link_state;
		logic [8:0]  frame_length;
		logic        frame_handoff;
		logic        enter_bootloader;
		logic        receiver_enable;
		logic        driver_enable;
		logic        tx_start;
		logic [8:0]  tx_length;
		logic        is_read;
	} ctrl_res_t;

	typedef struct packed {
		link_state_t link_state;
		logic [8:0]  frame_length;
		logic        frame_handoff;
		logic        enter_bootloader;
		logic        receiver_enable;
		logic        driver_enable;
		logic        tx_start;
		logic [8:0]  tx_length;
		logic [7:0]  read_data;
	} result_t;

endpackage
`default_nettype wire

[rtl/rtufl_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtufl_store: frame store memory
// Single-port synchronous memory, one write or one read per cycle, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
module rtufl_store (
	input  wire logic              clk,
	input  wire rtufl_pkg::mem_req_t req,
	output logic [7:0]             rdata
);

	logic [7:0] mem [rtufl_pkg::FRAME_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[rtl/rtufl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtufl_ctrl: link state machine, frame count, magic match and registers
// Decodes each accepted item, updates the link state, issues the frame store
// access and registers the control part of the result.
// ----------------------------------------------------------------------------
module rtufl_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [2:0]            cmd,
	input  wire logic [7:0]            data_byte,
	input  wire logic [7:0]            byte_index,
	input  wire logic                  reply_send,
	input  wire logic [8:0]            reply_length,
	input  wire logic                  cfg_write,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [63:0]           cfg_data,
	output rtufl_pkg::mem_req_t        mem_req,
	output logic                       valid_s1,
	output rtufl_pkg::ctrl_res_t       res_s1
);

	localparam int CNT_W = rtufl_pkg::CNT_W;

	rtufl_pkg::link_state_t state_q, state_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic                   match_q, match_d;
	logic [63:0]            magic_value_q;
	logic [3:0]             magic_length_q;
	logic                   magic_check_en_q;

	logic                   handoff, boot, start, is_read;
	logic [8:0]             txlen;
	logic [7:0]             magic_byte;
	logic                   idx_in_range;
	logic                   has_room;
	rtufl_pkg::ctrl_res_t   res_d;

	assign magic_byte   = magic_value_q[{count_q[2:0], 3'b000} +: 8];
	assign idx_in_range = 32'(byte_index) < 32'(rtufl_pkg::FRAME_BYTES);
	assign has_room     = count_q < CNT_W'(rtufl_pkg::FRAME_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_value_q    <= '0;
			magic_length_q   <= '0;
			magic_check_en_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (rtufl_pkg::cfg_index_t'(cfg_index))
				rtufl_pkg::CFG_MAGIC_VALUE:    magic_value_q    <= cfg_data;
				rtufl_pkg::CFG_MAGIC_LENGTH:   magic_length_q   <= cfg_data[3:0];
				rtufl_pkg::CFG_MAGIC_CHECK_EN: magic_check_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rtufl_pkg::LS_RX;
			count_q  <= '0;
			match_q  <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			match_q  <= match_d;
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		match_d = match_q;
		handoff = 1'b0;
		boot    = 1'b0;
		start   = 1'b0;
		txlen   = '0;
		is_read = 1'b0;
		mem_req = '0;
		if (accept) begin
			unique case (rtufl_pkg::cmd_t'(cmd))
				rtufl_pkg::CMD_RX_BYTE: begin
					if (state_q == rtufl_pkg::LS_RX || state_q == rtufl_pkg::LS_DONE) begin
						if (has_room) begin
							if (count_q < CNT_W'(rtufl_pkg::MAGIC_BYTES) &&
							    magic_byte != data_byte) begin
								match_d = 1'b0;
							end
							mem_req.we    = 1'b1;
							mem_req.addr  = count_q[rtufl_pkg::ADDR_W-1:0];
							mem_req.wdata = data_byte;
							count_d       = count_q + CNT_W'(1);
						end
						state_d = rtufl_pkg::LS_RX;
					end
				end
				rtufl_pkg::CMD_LINE_IDLE: begin
					if (state_q == rtufl_pkg::LS_RX && count_q != '0) begin
						state_d = rtufl_pkg::LS_DONE;
					end
				end
				rtufl_pkg::CMD_QUIET_TIMEOUT: begin
					if (state_q == rtufl_pkg::LS_DONE) begin
						handoff = 1'b1;
						boot    = magic_check_en_q && magic_length_q != 4'd0 &&
						          magic_length_q <= 4'd8 &&
						          count_q == CNT_W'(magic_length_q) && match_q;
						state_d = rtufl_pkg::LS_WAIT;
					end
				end
				rtufl_pkg::CMD_REPLY_READY: begin
					if (state_q == rtufl_pkg::LS_WAIT) begin
						if (reply_send) begin
							start   = 1'b1;
							txlen   = (32'(reply_length) > 32'(rtufl_pkg::FRAME_BYTES)) ?
							          9'(rtufl_pkg::FRAME_BYTES) : reply_length;
							state_d = rtufl_pkg::LS_TX;
						end else begin
							state_d = rtufl_pkg::LS_RX;
						end
						count_d = '0;
						match_d = 1'b1;
					end
				end
				rtufl_pkg::CMD_TX_COMPLETE: begin
					if (state_q == rtufl_pkg::LS_TX) begin
						state_d = rtufl_pkg::LS_RX;
					end
				end
				rtufl_pkg::CMD_READ: begin
					if (idx_in_range) begin
						is_read      = 1'b1;
						mem_req.re   = 1'b1;
						mem_req.addr = rtufl_pkg::ADDR_W'(byte_index);
					end
				end
				rtufl_pkg::CMD_WRITE: begin
					if (idx_in_range) begin
						mem_req.we    = 1'b1;
						mem_req.addr  = rtufl_pkg::ADDR_W'(byte_index);
						mem_req.wdata = data_byte;
					end
				end
				default: ;
			endcase
		end
		res_d.link_state       = state_d;
		res_d.frame_length     = 9'(count_d);
		res_d.frame_handoff    = handoff;
		res_d.enter_bootloader = boot;
		res_d.receiver_enable  = state_d == rtufl_pkg::LS_RX || state_d == rtufl_pkg::LS_DONE;
		res_d.driver_enable    = state_d == rtufl_pkg::LS_TX;
		res_d.tx_start         = start;
		res_d.tx_length        = txlen;
		res_d.is_read          = is_read;
	end

	a_s1_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> res_s1.link_state == state_q)
		else $error("result state differs from link state");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(rtufl_pkg::FRAME_BYTES))
		else $error("frame count above capacity");

	a_start_tx: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1.tx_start |-> state_q == rtufl_pkg::LS_TX && count_q == '0)
		else $error("tx start without transmit state or cleared frame");

	a_boot_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1.enter_bootloader |-> res_s1.frame_handoff &&
		state_q == rtufl_pkg::LS_WAIT)
		else $error("bootloader request without handoff");

endmodule
`default_nettype wire

[rtl/rtufl_outq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtufl_outq: two-entry result queue
// Joins the registered control result with the store read data and holds
// results while the receiver stalls; reports room for the next item.
// ----------------------------------------------------------------------------
module rtufl_outq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid_s1,
	input  wire rtufl_pkg::ctrl_res_t res_s1,
	input  wire logic [7:0]           rdata,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic                      in_room,
	output rtufl_pkg::result_t        head
);

	rtufl_pkg::result_t ent_q [2];
	rtufl_pkg::result_t push_res;
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         count_q;
	logic [1:0]         pend;
	logic               pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != 2'd0;
	assign head      = ent_q[rd_ptr_q];
	assign pend      = count_q + 2'(valid_s1);
	assign in_room   = pend < 2'd2 || (pend == 2'd2 && pop);

	always_comb begin
		push_res.link_state       = res_s1.link_state;
		push_res.frame_length     = res_s1.frame_length;
		push_res.frame_handoff    = res_s1.frame_handoff;
		push_res.enter_bootloader = res_s1.enter_bootloader;
		push_res.receiver_enable  = res_s1.receiver_enable;
		push_res.driver_enable    = res_s1.driver_enable;
		push_res.tx_start         = res_s1.tx_start;
		push_res.tx_length        = res_s1.tx_length;
		push_res.read_data        = res_s1.is_read ? rdata : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ent_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(valid_s1) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

[rtl/rtu_frame_link_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtu_frame_link_controller: half-duplex serial slave frame controller
// Input channel (in_valid/in_ready) carries one command item per handshake:
// received byte, line idle, quiet timeout, reply ready, tx complete, or a
// frame store read or write. Every item yields exactly one result item on
// the output channel (out_valid/out_ready) with the link state, frame
// length, handoff/bootloader/tx start pulses, enables and read data.
// Result path: the accepting edge issues the store access and registers the
// control result; the next edge lands the result in the queue, from which
// it is offered on the output channel.
// Throughput: one item per cycle while in_ready stays high, set by the single
// store port (at most one read or one write per item).
// Configuration (cfg_valid/cfg_ready, always ready) writes magic_value,
// magic_length and magic_check_enable by index; other indexes are ignored.
// Reset: link in receive, empty frame, magic cleared, check enabled; the
// store itself is not cleared and takes no clearing pass.
// Receiver stall: a two-entry queue holds results; once two results are
// queued or in flight, in_ready is high only in a cycle where the head item
// is taken.
// ----------------------------------------------------------------------------
module rtu_frame_link_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  cmd,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  byte_index,
	input  wire logic        reply_send,
	input  wire logic [8:0]  reply_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       link_state,
	output logic [8:0]       frame_length,
	output logic             frame_handoff,
	output logic             enter_bootloader,
	output logic             receiver_enable,
	output logic             driver_enable,
	output logic             tx_start,
	output logic [8:0]       tx_length,
	output logic [7:0]       read_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	rtufl_pkg::mem_req_t  mem_req;
	rtufl_pkg::ctrl_res_t res_s1;
	rtufl_pkg::result_t   head;
	logic                 valid_s1;
	logic                 accept;
	logic [7:0]           rdata;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	rtufl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.reply_send   (reply_send),
		.reply_length (reply_length),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mem_req      (mem_req),
		.valid_s1     (valid_s1),
		.res_s1       (res_s1)
	);

	rtufl_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	rtufl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_s1    (res_s1),
		.rdata     (rdata),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.in_room   (in_ready),
		.head      (head)
	);

	assign link_state       = head.link_state;
	assign frame_length     = head.frame_length;
	assign frame_handoff    = head.frame_handoff;
	assign enter_bootloader = head.enter_bootloader;
	assign receiver_enable  = head.receiver_enable;
	assign driver_enable    = head.driver_enable;
	assign tx_start         = head.tx_start;
	assign tx_length        = head.tx_length;
	assign read_data        = head.read_data;

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the RTU frame link controller
// Drives command items with random gaps, stalls the result side at random,
// predicts every result from its own copy of link state, frame store and
// magic settings, and checks each result item field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import rtufl_pkg::*;

	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          PHASE_ITEMS  = 165;
	localparam logic [2:0]  CMD_UNKNOWN  = 3'd7;
	localparam logic [1:0]  CFG_UNUSED   = 2'd3;

	class link_tracker;
		link_state_t state;
		logic [8:0]  count;
		bit          match_run;
		logic [63:0] magic;
		logic [3:0]  mlen;
		bit          check_en;
		logic [7:0]  store [FRAME_BYTES];
		bit          written [FRAME_BYTES];
		result_t     pending_status [$];
		int          errors;

		function new();
			state     = LS_RX;
			count     = '0;
			match_run = 1'b1;
			magic     = '0;
			mlen      = '0;
			check_en  = 1'b1;
			errors    = 0;
		endfunction

		function void set_reg(logic [1:0] i, logic [63:0] v);
			case (i)
				CFG_MAGIC_VALUE:    magic = v;
				CFG_MAGIC_LENGTH:   mlen = v[3:0];
				CFG_MAGIC_CHECK_EN: check_en = v[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_status.size();
		endfunction

		function void take_item(logic [2:0] c, logic [7:0] d, logic [7:0] idx, logic s,
				logic [8:0] rl);
			result_t e;
			e = '0;
			case (c)
				CMD_RX_BYTE: if (state == LS_RX || state == LS_DONE) begin
					if (count < FRAME_BYTES) begin
						if (count < MAGIC_BYTES) begin
							if (magic[8*count +: 8] != d)
								match_run = 1'b0;
						end
						store[count]   = d;
						written[count] = 1'b1;
						count++;
					end
					state = LS_RX;
				end
				CMD_LINE_IDLE: if (state == LS_RX && count != 0) begin
					state = LS_DONE;
				end
				CMD_QUIET_TIMEOUT: if (state == LS_DONE) begin
					e.frame_handoff    = 1'b1;
					e.enter_bootloader = check_en && mlen != 0 && mlen <= MAGIC_BYTES &&
						count == mlen && match_run;
					state = LS_WAIT;
				end
				CMD_REPLY_READY: if (state == LS_WAIT) begin
					if (s) begin
						e.tx_start  = 1'b1;
						e.tx_length = (rl > FRAME_BYTES) ? 9'(FRAME_BYTES) : rl;
						state = LS_TX;
					end else begin
						state = LS_RX;
					end
					count     = '0;
					match_run = 1'b1;
				end
				CMD_TX_COMPLETE: if (state == LS_TX) begin
					state = LS_RX;
				end
				CMD_READ: e.read_data = store[idx];
				CMD_WRITE: begin
					store[idx]   = d;
					written[idx] = 1'b1;
				end
				default: ;
			endcase
			e.link_state      = state;
			e.frame_length    = count;
			e.receiver_enable = (state == LS_RX || state == LS_DONE);
			e.driver_enable   = (state == LS_TX);
			pending_status.push_back(e);
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("tb_top: mismatch: %s", msg);
			errors++;
		endtask

		task field(string name, logic [8:0] got, logic [8:0] want);
			if (got !== want)
				report($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_result(result_t got);
			result_t e;
			if (pending_status.size() == 0) begin
				report("result item with no item waiting");
				return;
			end
			e = pending_status.pop_front();
			field("link_state", got.link_state, e.link_state);
			field("frame_length", got.frame_length, e.frame_length);
			field("frame_handoff", got.frame_handoff, e.frame_handoff);
			field("enter_bootloader", got.enter_bootloader, e.enter_bootloader);
			field("receiver_enable", got.receiver_enable, e.receiver_enable);
			field("driver_enable", got.driver_enable, e.driver_enable);
			field("tx_start", got.tx_start, e.tx_start);
			field("tx_length", got.tx_length, e.tx_length);
			field("read_data", got.read_data, e.read_data);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  cmd;
	logic [7:0]  data_byte;
	logic [7:0]  byte_index;
	logic        reply_send;
	logic [8:0]  reply_length;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  link_state;
	logic [8:0]  frame_length;
	logic        frame_handoff;
	logic        enter_bootloader;
	logic        receiver_enable;
	logic        driver_enable;
	logic        tx_start;
	logic [8:0]  tx_length;
	logic [7:0]  read_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	link_tracker track;
	bit          steady;
	int          items_sent;
	int          cycles;

	rtu_frame_link_controller dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.data_byte        (data_byte),
		.byte_index       (byte_index),
		.reply_send       (reply_send),
		.reply_length     (reply_length),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.link_state       (link_state),
		.frame_length     (frame_length),
		.frame_handoff    (frame_handoff),
		.enter_bootloader (enter_bootloader),
		.receiver_enable  (receiver_enable),
		.driver_enable    (driver_enable),
		.tx_start         (tx_start),
		.tx_length        (tx_length),
		.read_data        (read_data),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 23);
	end

	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.link_state       = link_state_t'(link_state);
			got.frame_length     = frame_length;
			got.frame_handoff    = frame_handoff;
			got.enter_bootloader = enter_bootloader;
			got.receiver_enable  = receiver_enable;
			got.driver_enable    = driver_enable;
			got.tx_start         = tx_start;
			got.tx_length        = tx_length;
			got.read_data        = read_data;
			track.check_result(got);
		end
	end

	task drive_item(logic [2:0] c, logic [7:0] d, logic [7:0] idx, logic s, logic [8:0] rl);
		while (!steady && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		data_byte    <= d;
		byte_index   <= idx;
		reply_send   <= s;
		reply_length <= rl;
		do @(posedge clk); while (!in_ready);
		track.take_item(c, d, idx, s, rl);
		items_sent++;
	endtask

	// fill the unused fields at random; reads prefer entries already written and fall back to entry 0
	task send_cmd(logic [2:0] c, logic [7:0] d);
		logic [7:0] idx;
		logic [8:0] rl;
		int         tries;
		idx = 8'($urandom_range(255));
		if (c == CMD_READ) begin
			tries = 0;
			while (!track.written[idx] && tries < 64) begin
				idx = 8'($urandom_range(255));
				tries++;
			end
			if (!track.written[idx])
				idx = 8'd0;
		end
		case ($urandom_range(7))
			0: rl = 9'd0;
			1: rl = 9'd256;
			2: rl = 9'd257;
			default: rl = 9'($urandom_range(511));
		endcase
		drive_item(c, d, idx, 1'($urandom_range(1)), rl);
	endtask

	task slave_access();
		if ($urandom_range(1))
			send_cmd(CMD_WRITE, 8'($urandom_range(255)));
		else
			send_cmd(CMD_READ, 8'($urandom_range(255)));
	endtask

	task frame_exchange(bit overflow);
		int         n;
		int         kind;
		int         bad;
		int         k;
		logic [7:0] b;
		kind = $urandom_range(99);
		n    = (track.mlen == 0) ? $urandom_range(1, 8) : int'(track.mlen);
		bad  = -1;
		if (overflow)
			n = FRAME_BYTES + $urandom_range(1, 6);
		else if (kind >= 50)
			n = $urandom_range(1, 12);
		else if (kind >= 40)
			n = n + 1;
		else if (kind >= 30)
			bad = $urandom_range(0, n - 1);
		for (k = 0; k < n; k++) begin
			b = 8'($urandom_range(255));
			if (kind < 50 && k < MAGIC_BYTES)
				b = track.magic[8*k +: 8];
			if (k == bad)
				b = ~b;
			send_cmd(CMD_RX_BYTE, b);
			if ($urandom_range(9) == 0)
				slave_access();
		end
		if ($urandom_range(12) == 0)
			send_cmd(3'($urandom_range(7)), 8'($urandom_range(255)));
		send_cmd(CMD_LINE_IDLE, 8'($urandom_range(255)));
		if ($urandom_range(9) == 0) begin
			send_cmd(CMD_RX_BYTE, 8'($urandom_range(255)));
			send_cmd(CMD_LINE_IDLE, 8'($urandom_range(255)));
		end
		if ($urandom_range(19) == 0)
			return;
		if ($urandom_range(9) == 0)
			send_cmd($urandom_range(1) ? CMD_REPLY_READY : CMD_TX_COMPLETE,
				8'($urandom_range(255)));
		send_cmd(CMD_QUIET_TIMEOUT, 8'($urandom_range(255)));
		repeat ($urandom_range(0, 3)) slave_access();
		if ($urandom_range(9) == 0)
			send_cmd(CMD_RX_BYTE, 8'($urandom_range(255)));
		send_cmd(CMD_REPLY_READY, 8'($urandom_range(255)));
		repeat ($urandom_range(0, 2)) begin
			if ($urandom_range(3) == 0)
				send_cmd(CMD_RX_BYTE, 8'($urandom_range(255)));
			else
				slave_access();
		end
		send_cmd(CMD_TX_COMPLETE, 8'($urandom_range(255)));
	endtask

	task write_reg(logic [1:0] i, logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= i;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		track.set_reg(i, v);
	endtask

	task configure(logic [63:0] mv, logic [3:0] ml, logic me);
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		write_reg(CFG_MAGIC_VALUE, mv);
		write_reg(CFG_MAGIC_LENGTH, {noise[63:4], ml});
		write_reg(CFG_MAGIC_CHECK_EN, {noise[63:1], me});
		cfg_valid <= 1'b0;
	endtask

	task drain();
		in_valid <= 1'b0;
		while (track.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int          p;
		int          base;
		logic [63:0] mv;
		logic [3:0]  ml;
		logic        me;
		track        = new();
		steady       = 1'b0;
		items_sent   = 0;
		cycles       = 0;
		arst_n       = 1'b0;
		in_valid     <= 1'b0;
		cmd          <= CMD_RX_BYTE;
		data_byte    <= '0;
		byte_index   <= '0;
		reply_send   <= 1'b0;
		reply_length <= '0;
		out_ready    <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_MAGIC_VALUE;
		cfg_data     <= '0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_UNUSED, {$urandom, $urandom});
		configure(64'h5A_FF00, 4'd3, 1'b1);

		drive_item(CMD_WRITE, 8'hFF, 8'd255, 1'b0, 9'd0);
		drive_item(CMD_WRITE, 8'h00, 8'd0, 1'b1, 9'h1FF);
		drive_item(CMD_READ, 8'h00, 8'd255, 1'b0, 9'd0);
		drive_item(CMD_READ, 8'hFF, 8'd0, 1'b1, 9'h1FF);
		drive_item(CMD_LINE_IDLE, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_QUIET_TIMEOUT, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_REPLY_READY, 8'h00, 8'd0, 1'b1, 9'd5);
		drive_item(CMD_TX_COMPLETE, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_UNKNOWN, 8'hFF, 8'hFF, 1'b1, 9'h1FF);
		drive_item(CMD_RX_BYTE, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_RX_BYTE, 8'hFF, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_LINE_IDLE, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_RX_BYTE, 8'h5A, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_LINE_IDLE, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_QUIET_TIMEOUT, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_RX_BYTE, 8'h11, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_REPLY_READY, 8'h00, 8'd0, 1'b1, 9'h1FF);
		drive_item(CMD_RX_BYTE, 8'h22, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_LINE_IDLE, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_TX_COMPLETE, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_RX_BYTE, 8'h77, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_LINE_IDLE, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_QUIET_TIMEOUT, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_REPLY_READY, 8'h00, 8'd0, 1'b0, 9'd0);
		drive_item(CMD_READ, 8'h00, 8'd2, 1'b0, 9'd0);
		drain();

		for (p = 0; p < 8; p++) begin
			mv = {$urandom, $urandom};
			me = 1'b1;
			case (p)
				0: ml = 4'd4;
				1: begin
					mv = '0;
					ml = 4'd1;
				end
				2: begin
					mv = '1;
					ml = 4'd8;
				end
				3: begin
					ml = 4'd8;
					me = 1'b0;
				end
				4: ml = 4'd9;
				5: ml = 4'd15;
				6: ml = 4'd0;
				default: ml = 4'd2;
			endcase
			configure(mv, ml, me);
			steady = (p == 3);
			if (p == 2 || p == 5)
				frame_exchange(1'b1);
			base = items_sent;
			while (items_sent - base < PHASE_ITEMS) begin
				if ($urandom_range(99) < 15)
					send_cmd(3'($urandom_range(7)), 8'($urandom_range(255)));
				else
					frame_exchange(1'b0);
			end
			drain();
		end
		steady = 1'b0;
		repeat (10) @(posedge clk);

		if (track.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/rtufl_pkg.sv
rtl/rtufl_store.sv
rtl/rtufl_ctrl.sv
rtl/rtufl_outq.sv
rtl/rtu_frame_link_controller.sv
dv/tb_top.sv
